// ----- rtl/core/pgds_pkg.sv -----
package pgds_pkg;

    // Item operation codes
    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_COMPUTE = 2'd1;
    localparam logic [1:0] FUNC_SWAP    = 2'd2;
    localparam logic [1:0] FUNC_READ    = 2'd3;

    // Stencil weights in unsigned Q0.16
    localparam logic [15:0] WEIGHT_UP   = 16'd16384;
    localparam logic [15:0] WEIGHT_REST = 16'd49152;
    localparam logic [14:0] WEIGHT_MAX  = 15'd24576;
    localparam logic [14:0] WEIGHT_RST  = 15'd16384;

    // Neighbor fetch order of a compute item
    localparam logic [1:0] NBR_UP    = 2'd0;
    localparam logic [1:0] NBR_RIGHT = 2'd1;
    localparam logic [1:0] NBR_LEFT  = 2'd2;
    localparam logic [1:0] NBR_DOWN  = 2'd3;

    typedef logic [31:0] cell_t;

endpackage

// ----- rtl/core/periodic_grid_diffusion_stencil.sv -----
// Periodic diffusion stencil on a square torus grid of 2^SIDE_BITS by 2^SIDE_BITS
// unsigned 32-bit cells, held in two single-port banks that swap roles as current
// and next. Each item carries func, col and row (only the low SIDE_BITS bits of a
// coordinate are used) and cell_in, and returns exactly one cell_out: write stores
// cell_in into the current bank and returns 0, swap exchanges the banks and
// returns 0, read returns a current cell, and compute forms
// 0.25*up + p*right + p*left + (0.75-2p)*down from the current bank, stores it in
// the next bank at (col,row) and returns it. p is side_weight in Q0.16, clamped to
// 24576; each product is truncated to 32 bits before the sum. Items are handled
// one at a time: write and swap go from acceptance through S_DONE to the result
// register, read waits in S_RDWAIT for its bank data first, and compute walks the
// four neighbor reads one by one through the single port of the current bank,
// feeding a multiply stage and an accumulate stage. A result waiting on the output
// register does not block acceptance of the next item. There is no clearing pass
// after reset; a cell must be written before it is read.
module periodic_grid_diffusion_stencil
    import pgds_pkg::*;
#(
    parameter int SIDE_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  col,
    input  logic [7:0]  row,
    input  logic [31:0] cell_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] cell_out,
    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data
);

    localparam int ADDR_BITS = 2 * SIDE_BITS;
    localparam int DEPTH     = 1 << ADDR_BITS;

    // Sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RDWAIT = 2'd1;
    localparam logic [1:0] S_CALC   = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    // Compute steps: issue reads on 0..3, multiply on 1..4, accumulate on 2..5,
    // write the new cell on the last one
    localparam logic [2:0] STEP_FIRST_MUL = 3'd1;
    localparam logic [2:0] STEP_LAST_MUL  = 3'd4;
    localparam logic [2:0] STEP_FIRST_ACC = 3'd2;
    localparam logic [2:0] STEP_LAST_ACC  = 3'd5;
    localparam logic [2:0] STEP_LAST      = 3'd6;

    // Grid banks
    cell_t mem_a [DEPTH];
    cell_t mem_b [DEPTH];
    cell_t rdata_a_reg;
    cell_t rdata_b_reg;

    logic [1:0]           state_reg, state_next;
    logic [2:0]           step_reg, step_next;
    logic                 bank_sel_reg, bank_sel_next;
    logic [14:0]          side_weight_reg;
    logic [14:0]          p_reg, p_next;
    logic [SIDE_BITS-1:0] x_reg, x_next;
    logic [SIDE_BITS-1:0] y_reg, y_next;
    cell_t                prod_reg, prod_next;
    cell_t                acc_reg, acc_next;
    cell_t                res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;
    cell_t                cell_out_reg, cell_out_next;

    logic                 in_accept;
    logic                 out_free;
    logic [SIDE_BITS-1:0] in_x;
    logic [SIDE_BITS-1:0] in_y;
    logic [SIDE_BITS-1:0] nbr_x;
    logic [SIDE_BITS-1:0] nbr_y;
    logic [ADDR_BITS-1:0] mem_addr;
    logic                 we_a;
    logic                 we_b;
    cell_t                wdata;
    cell_t                rdata_cur;
    logic [1:0]           mul_nbr;
    logic [15:0]          wsel;
    logic [15:0]          wdown;
    logic [47:0]          prod_full;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign cell_out  = cell_out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Coordinates wrap naturally at SIDE_BITS
    assign in_x = SIDE_BITS'(col);
    assign in_y = SIDE_BITS'(row);

    assign rdata_cur = bank_sel_reg ? rdata_b_reg : rdata_a_reg;
    assign wdown     = WEIGHT_REST - {p_reg, 1'b0};

    // Pick the neighbor for the read issued at this step
    always_comb
    begin
        nbr_x = x_reg;
        nbr_y = y_reg;
        case (step_reg[1:0])
            NBR_UP:    nbr_y = SIDE_BITS'(y_reg + 1'b1);
            NBR_RIGHT: nbr_x = SIDE_BITS'(x_reg + 1'b1);
            NBR_LEFT:  nbr_x = SIDE_BITS'(x_reg - 1'b1);
            NBR_DOWN:  nbr_y = SIDE_BITS'(y_reg - 1'b1);
            default:   nbr_x = x_reg;
        endcase
    end

    // Weight of the neighbor whose read data arrives this cycle
    assign mul_nbr = 2'(step_reg - STEP_FIRST_MUL);

    always_comb
    begin
        case (mul_nbr)
            NBR_UP:    wsel = WEIGHT_UP;
            NBR_RIGHT: wsel = {1'b0, p_reg};
            NBR_LEFT:  wsel = {1'b0, p_reg};
            NBR_DOWN:  wsel = wdown;
            default:   wsel = WEIGHT_UP;
        endcase
    end

    assign prod_full = {16'd0, rdata_cur} * {32'd0, wsel};

    // Memory port control: the accept cycle addresses the item's own cell, the
    // first compute steps walk the neighbors, the last step writes the center
    always_comb
    begin
        mem_addr = {y_reg, x_reg};
        we_a     = 1'b0;
        we_b     = 1'b0;
        wdata    = cell_in;
        if (state_reg == S_IDLE)
        begin
            mem_addr = {in_y, in_x};
            if (in_accept && func == FUNC_WRITE)
            begin
                we_a = !bank_sel_reg;
                we_b = bank_sel_reg;
            end
        end
        else if (state_reg == S_CALC)
        begin
            if (step_reg <= 3'd3)
            begin
                mem_addr = {nbr_y, nbr_x};
            end
            if (step_reg == STEP_LAST)
            begin
                // Next bank takes the new cell
                we_a  = bank_sel_reg;
                we_b  = !bank_sel_reg;
                wdata = acc_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[mem_addr] <= wdata;
        end
        rdata_a_reg <= mem_a[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we_b)
        begin
            mem_b[mem_addr] <= wdata;
        end
        rdata_b_reg <= mem_b[mem_addr];
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        bank_sel_next  = bank_sel_reg;
        p_next         = p_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        cell_out_next  = cell_out_reg;

        // Drop the result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    x_next   = in_x;
                    y_next   = in_y;
                    res_next = '0;
                    case (func)
                        FUNC_WRITE:
                        begin
                            state_next = S_DONE;
                        end
                        FUNC_COMPUTE:
                        begin
                            // Clamp p so the down weight stays non-negative
                            p_next     = (side_weight_reg > WEIGHT_MAX) ? WEIGHT_MAX
                                                                        : side_weight_reg;
                            acc_next   = '0;
                            step_next  = '0;
                            state_next = S_CALC;
                        end
                        FUNC_SWAP:
                        begin
                            bank_sel_next = !bank_sel_reg;
                            state_next    = S_DONE;
                        end
                        FUNC_READ:
                        begin
                            state_next = S_RDWAIT;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                res_next   = rdata_cur;
                state_next = S_DONE;
            end
            S_CALC:
            begin
                if (step_reg >= STEP_FIRST_MUL && step_reg <= STEP_LAST_MUL)
                begin
                    prod_next = prod_full[47:16];
                end
                if (step_reg >= STEP_FIRST_ACC && step_reg <= STEP_LAST_ACC)
                begin
                    acc_next = acc_reg + prod_reg;
                end
                if (step_reg == STEP_LAST)
                begin
                    res_next   = acc_reg;
                    step_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    cell_out_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            step_reg        <= '0;
            bank_sel_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            side_weight_reg <= WEIGHT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            bank_sel_reg  <= bank_sel_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                side_weight_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        res_reg      <= res_next;
        cell_out_reg <= cell_out_next;
    end

`ifndef SYNTHESIS
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CALC) |-> (step_reg == 3'd0))
        else $error("step counter running outside compute");

    a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(we_a && we_b))
        else $error("both banks written in one cycle");

    a_swap_only_on_item: assert property (@(posedge clk) disable iff (!rst_n)
        (bank_sel_reg != $past(bank_sel_reg))
            |-> $past(in_valid && !in_stall && func == FUNC_SWAP))
        else $error("bank select changed without a swap item");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(cell_out_reg)))
        else $error("waiting result overwritten");
`endif

endmodule

// ----- verif/grid_mirror_pkg.sv -----
package grid_mirror_pkg;

    import pgds_pkg::*;

    // Shadow copy of both grid banks, the bank select and the side weight.
    // Each accepted item is folded into the copy and its expected cell_out
    // is queued; each accepted result is checked against the oldest one.
    class grid_mirror;

        cell_t       cells [2][65536];
        bit          filled [2][65536];
        bit          cur_bank;
        logic [14:0] weight;
        cell_t       pending_cells [$];
        int          errors;

        function new();
            cur_bank = 1'b0;
            weight   = WEIGHT_RST;
            errors   = 0;
        endfunction

        function bit is_filled(logic [7:0] cx, logic [7:0] cy);
            return filled[cur_bank][{cy, cx}];
        endfunction

        // Q0.16 product, truncated toward zero
        function cell_t scaled(cell_t c, logic [16:0] w);
            logic [63:0] prod;
            prod = {32'd0, c} * {47'd0, w};
            return prod[47:16];
        endfunction

        function cell_t stencil_cell(logic [7:0] cx, logic [7:0] cy);
            logic [16:0] p;
            logic [16:0] w_down;
            logic [7:0]  x_right;
            logic [7:0]  x_left;
            logic [7:0]  y_up;
            logic [7:0]  y_down;
            logic [33:0] total;
            p       = (weight > WEIGHT_MAX) ? {2'b00, WEIGHT_MAX} : {2'b00, weight};
            w_down  = {1'b0, WEIGHT_REST} - (p << 1);
            x_right = cx + 8'd1;
            x_left  = cx - 8'd1;
            y_up    = cy + 8'd1;
            y_down  = cy - 8'd1;
            total   = {2'b00, scaled(cells[cur_bank][{y_up, cx}], {1'b0, WEIGHT_UP})}
                    + {2'b00, scaled(cells[cur_bank][{cy, x_right}], p)}
                    + {2'b00, scaled(cells[cur_bank][{cy, x_left}], p)}
                    + {2'b00, scaled(cells[cur_bank][{y_down, cx}], w_down)};
            return total[31:0];
        endfunction

        function void note_item(logic [1:0] op, logic [7:0] cx, logic [7:0] cy,
                                cell_t value);
            cell_t fresh;
            case (op)
                FUNC_WRITE:
                begin
                    cells[cur_bank][{cy, cx}]  = value;
                    filled[cur_bank][{cy, cx}] = 1'b1;
                    pending_cells.push_back('0);
                end
                FUNC_COMPUTE:
                begin
                    fresh = stencil_cell(cx, cy);
                    cells[!cur_bank][{cy, cx}]  = fresh;
                    filled[!cur_bank][{cy, cx}] = 1'b1;
                    pending_cells.push_back(fresh);
                end
                FUNC_SWAP:
                begin
                    cur_bank = !cur_bank;
                    pending_cells.push_back('0);
                end
                default:
                begin
                    pending_cells.push_back(cells[cur_bank][{cy, cx}]);
                end
            endcase
        endfunction

        function void check_cell(cell_t actual);
            cell_t want;
            if (pending_cells.size() == 0)
            begin
                $error("cell_out: no item pending, actual 0x%08h", actual);
                errors++;
            end
            else
            begin
                want = pending_cells.pop_front();
                if (actual !== want)
                begin
                    $error("cell_out mismatch: expected 0x%08h, actual 0x%08h", want, actual);
                    errors++;
                end
            end
        endfunction

    endclass

endpackage

// ----- verif/tb_periodic_grid_diffusion_stencil.sv -----
module tb_periodic_grid_diffusion_stencil;

    import pgds_pkg::*;
    import grid_mirror_pkg::*;

    localparam int PHASE_COUNT     = 6;
    localparam int PHASE_ITEMS     = 172;
    // Long receiver hold-off: far longer than the block can buffer
    localparam int HOLD_OFF_CYCLES = 200;
    // Cycles without any accepted item or result before the run is declared hung
    localparam int STUCK_LIMIT     = 4000;
    // Settle time after the last result
    localparam int SETTLE_CYCLES   = 20;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [31:0] cell_in;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] cell_out;
    logic        cfg_wr_en;
    logic [14:0] cfg_wr_data;

    grid_mirror  mirror;
    int          items_sent = 0;
    int          sender_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_off_req = 1'b0;
    logic [7:0]  window_base = 8'd0;

    periodic_grid_diffusion_stencil #(
        .SIDE_BITS   (8)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .col         (col),
        .row         (row),
        .cell_in     (cell_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cell_out    (cell_out),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Offer one item and hold it until the block takes it. Valid stays high
    // after acceptance unless an idle gap follows, so back-to-back items never
    // drop and raise valid within the same step.
    task automatic send_item(input logic [1:0] op, input logic [7:0] cx,
                             input logic [7:0] cy, input cell_t value);
        int gap;
        gap = 0;
        func     <= op;
        col      <= cx;
        row      <= cy;
        cell_in  <= value;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        mirror.note_item(op, cx, cy, value);
        items_sent++;
        // Draw a geometric idle gap at the sender's current idle rate
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid once the last item of a phase has gone in.
    task automatic release_input();
        in_valid <= 1'b0;
    endtask

    // Wait until every expected result has come back; the watchdog
    // covers a block that never answers.
    task automatic drain_results();
        while (mirror.pending_cells.size() != 0)
            @(posedge clk);
    endtask

    // Write the side weight while the block is idle.
    task automatic write_weight(input logic [14:0] w);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mirror.weight = w;
    endtask

    // Half the coordinates land in a small window so cells get reused and
    // neighbors are already present; the rest span the whole 8-bit range.
    function automatic logic [7:0] pick_coord();
        if ($urandom_range(1) == 1)
            return 8'($urandom_range(255));
        return 8'(window_base + $urandom_range(7));
    endfunction

    function automatic cell_t pick_value();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Write a cell of the current bank first if it holds nothing yet, so
    // no read or compute ever touches an unwritten entry.
    task automatic fill_cell(input logic [7:0] cx, input logic [7:0] cy);
        if (!mirror.is_filled(cx, cy))
            send_item(FUNC_WRITE, cx, cy, pick_value());
    endtask

    // One random operation; reads and computes are preceded by the writes
    // they need, so most traffic forms complete, legal sequences.
    task automatic random_op();
        int          pick;
        logic [7:0]  cx;
        logic [7:0]  cy;
        pick = $urandom_range(99);
        cx   = pick_coord();
        cy   = pick_coord();
        if (pick < 40)
        begin
            fill_cell(cx, cy + 8'd1);
            fill_cell(cx + 8'd1, cy);
            fill_cell(cx - 8'd1, cy);
            fill_cell(cx, cy - 8'd1);
            send_item(FUNC_COMPUTE, cx, cy, $urandom);
        end
        else if (pick < 65)
        begin
            send_item(FUNC_WRITE, cx, cy, pick_value());
        end
        else if (pick < 90)
        begin
            fill_cell(cx, cy);
            send_item(FUNC_READ, cx, cy, $urandom);
        end
        else
        begin
            send_item(FUNC_SWAP, 8'($urandom), 8'($urandom), $urandom);
        end
    endtask

    // Directed items at the reset weight: all-ones neighbors around the
    // origin (wrap in both axes, largest sum), reads of both banks across
    // swaps, and a compute at the far corner with mixed extreme values.
    task automatic run_directed();
        send_item(FUNC_WRITE, 8'd0, 8'd0, 32'h0000_0000);
        send_item(FUNC_WRITE, 8'd0, 8'd1, 32'hFFFF_FFFF);
        send_item(FUNC_WRITE, 8'd1, 8'd0, 32'hFFFF_FFFF);
        send_item(FUNC_WRITE, 8'd255, 8'd0, 32'hFFFF_FFFF);
        send_item(FUNC_WRITE, 8'd0, 8'd255, 32'hFFFF_FFFF);
        send_item(FUNC_COMPUTE, 8'd0, 8'd0, 32'hFFFF_FFFF);
        send_item(FUNC_READ, 8'd255, 8'd0, 32'h0000_0000);
        send_item(FUNC_READ, 8'd0, 8'd0, 32'hFFFF_FFFF);
        // Swap ignores its coordinates and data; drive them at full scale
        send_item(FUNC_SWAP, 8'd255, 8'd255, 32'hFFFF_FFFF);
        send_item(FUNC_READ, 8'd0, 8'd0, 32'h1234_5678);
        send_item(FUNC_WRITE, 8'd255, 8'd0, 32'h0000_0000);
        send_item(FUNC_WRITE, 8'd0, 8'd255, 32'h0000_0001);
        send_item(FUNC_WRITE, 8'd254, 8'd255, 32'h8000_0000);
        send_item(FUNC_WRITE, 8'd255, 8'd254, 32'hFFFF_FFFF);
        send_item(FUNC_COMPUTE, 8'd255, 8'd255, 32'h0000_0000);
        send_item(FUNC_SWAP, 8'd0, 8'd0, 32'h0000_0000);
        send_item(FUNC_READ, 8'd255, 8'd255, 32'hFFFF_FFFF);
    endtask

    // Receiver: stall at random at the current rate; on request hold off
    // for a long stretch so the block backs up and stalls its input.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Check every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            mirror.check_cell(cell_out);
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                stuck = 0;
            else
                stuck++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int          phase;
        int          target;
        logic [14:0] w;
        mirror = new();
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        func        <= FUNC_WRITE;
        col         <= 8'd0;
        row         <= 8'd0;
        cell_in     <= 32'd0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 15'd0;
        sender_idle_pct = 33;
        recv_idle_pct   = 46;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            release_input();
            drain_results();
            // Idle pattern: receiver-heavy, then sender-heavy, then none
            if (phase < 2)
            begin
                sender_idle_pct = 33;
                recv_idle_pct   = 46;
            end
            else if (phase < 4)
            begin
                sender_idle_pct = 46;
                recv_idle_pct   = 33;
            end
            else
            begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
            end
            // Weight sweep: zero, the limit, full scale (saturates), and
            // random values below and above the limit
            case (phase)
                0: w = 15'd0;
                1: w = WEIGHT_MAX;
                2: w = 15'h7FFF;
                3: w = 15'($urandom_range(1, 24575));
                4: w = 15'($urandom_range(24577, 32766));
                default: w = 15'($urandom_range(0, 24576));
            endcase
            write_weight(w);
            // First phase works in a window that wraps past the grid edge
            if (phase == 0)
                window_base = 8'd252;
            else
                window_base = 8'($urandom_range(255));
            if (phase == 4)
                hold_off_req = 1'b1;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                random_op();
        end

        release_input();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mirror.pending_cells.size() != 0)
        begin
            $error("cell_out: %0d results never arrived", mirror.pending_cells.size());
            mirror.errors++;
        end
        if (mirror.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/pgds_pkg.sv
rtl/core/periodic_grid_diffusion_stencil.sv
verif/grid_mirror_pkg.sv
verif/tb_periodic_grid_diffusion_stencil.sv
